// ----- hw/rtl/rlkc_pkg.sv -----
// ----------------------------------------------------------------------------
// rlkc_pkg
// Types, ladder thresholds and codes shared by the keypad controller.
// ----------------------------------------------------------------------------
package rlkc_pkg;

   localparam int ADC_W  = 10;
   localparam int CODE_W = 3;
   localparam int TICK_W = 32;
   localparam int REG_W  = 16;
   localparam int CSR_IDX_W = 2;

   typedef logic [CODE_W-1:0] code_type;
   typedef logic [TICK_W-1:0] tick_type;
   typedef logic [REG_W-1:0]  reg_type;

   localparam logic [ADC_W-1:0] THR_MIN  = 10'd500;
   localparam logic [ADC_W-1:0] THR_UP   = 10'd580;
   localparam logic [ADC_W-1:0] THR_DOWN = 10'd650;
   localparam logic [ADC_W-1:0] THR_SEL  = 10'd720;
   localparam logic [ADC_W-1:0] THR_UD   = 10'd765;
   localparam logic [ADC_W-1:0] THR_US   = 10'd794;
   localparam logic [ADC_W-1:0] THR_DS   = 10'd824;
   localparam logic [ADC_W-1:0] THR_ALL  = 10'd900;

   localparam code_type KEY_NONE   = 3'b000;
   localparam code_type KEY_UP     = 3'b001;
   localparam code_type KEY_DOWN   = 3'b010;
   localparam code_type KEY_SELECT = 3'b100;

   localparam logic EVENT_KEY     = 1'b0;
   localparam logic EVENT_TIMEOUT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_STANDARD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REDUCED  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE     = 2'd2;

   localparam reg_type STANDARD_RESET = 16'd10;
   localparam reg_type REDUCED_RESET  = 16'd4;
   localparam reg_type IDLE_RESET     = 16'd1200;

   typedef struct packed {
      reg_type standard_repeat;
      reg_type reduced_repeat;
      reg_type idle_timeout;
   } cfg_type;

   typedef struct packed {
      code_type code;
      logic     agreed;
      logic     line;
      tick_type date;
   } class_item_type;

   typedef struct packed {
      code_type key_code;
      logic     event_kind;
      logic     screen_on;
   } rsp_item_type;

   function automatic code_type decode_ladder(input logic [ADC_W-1:0] v);
      code_type c;
      priority if (v <= THR_MIN) c = KEY_NONE;
      else if (v < THR_UP)       c = KEY_UP;
      else if (v < THR_DOWN)     c = KEY_DOWN;
      else if (v < THR_SEL)      c = KEY_SELECT;
      else if (v < THR_UD)       c = KEY_UP | KEY_DOWN;
      else if (v < THR_US)       c = KEY_UP | KEY_SELECT;
      else if (v < THR_DS)       c = KEY_DOWN | KEY_SELECT;
      else if (v < THR_ALL)      c = KEY_UP | KEY_DOWN | KEY_SELECT;
      else                       c = KEY_NONE;
      return c;
   endfunction

endpackage

// ----- hw/rtl/rlkc_queue.sv -----
// ----------------------------------------------------------------------------
// rlkc_queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module rlkc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/rlkc_front.sv -----
// ----------------------------------------------------------------------------
// rlkc_front
// Decodes each ladder sample, checks agreement with the previous sample
// and stamps it with the tick count.
// ----------------------------------------------------------------------------
module rlkc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [rlkc_pkg::ADC_W-1:0]    adc_sample,
   input  logic                          key_line_high,
   output rlkc_pkg::class_item_type      item
);
   import rlkc_pkg::*;

   code_type previous_code_ff, previous_code_in;
   tick_type tick_ff, tick_in;
   code_type code;

   assign code = key_line_high ? decode_ladder(adc_sample) : KEY_NONE;

   always_comb begin
      item.code   = code;
      item.agreed = (code == previous_code_ff);
      item.line   = key_line_high;
      item.date   = tick_ff;
      previous_code_in = accept ? code : previous_code_ff;
      tick_in          = accept ? tick_ff + TICK_W'(1) : tick_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_code_ff <= KEY_NONE;
         tick_ff          <= '0;
      end else begin
         previous_code_ff <= previous_code_in;
         tick_ff          <= tick_in;
      end
   end

endmodule

// ----- hw/rtl/rlkc_back.sv -----
// ----------------------------------------------------------------------------
// rlkc_back
// Applies autorepeat, last-key tracking and idle timeout to classified
// samples and produces key and timeout events.
// ----------------------------------------------------------------------------
module rlkc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  rlkc_pkg::cfg_type          cfg,
   input  rlkc_pkg::class_item_type   item,
   input  logic                       item_valid,
   output logic                       item_pop,
   input  logic                       out_full,
   output logic                       out_push,
   output rlkc_pkg::rsp_item_type     out_item
);
   import rlkc_pkg::*;

   code_type last_key_ff, last_key_in;
   tick_type last_event_ff, last_event_in;
   reg_type  active_delay_ff, active_delay_in;
   logic     screen_ff, screen_in;
   tick_type elapsed;
   logic     screen_now;
   logic     fire;

   assign item_pop   = item_valid && !out_full;
   assign elapsed    = item.date - last_event_ff;
   assign screen_now = item.line ? 1'b1 : screen_ff;

   always_comb begin
      last_key_in     = last_key_ff;
      last_event_in   = last_event_ff;
      active_delay_in = active_delay_ff;
      screen_in       = screen_now;
      fire            = 1'b0;
      out_item.key_code   = item.code;
      out_item.event_kind = EVENT_KEY;
      if (item.agreed) begin
         if (item.code != KEY_NONE) begin
            if (item.code != last_key_ff ||
                elapsed > {{(TICK_W-REG_W){1'b0}}, active_delay_ff}) begin
               active_delay_in = (item.code == last_key_ff) ? cfg.reduced_repeat
                                                            : cfg.standard_repeat;
               last_key_in     = item.code;
               last_event_in   = item.date;
               fire            = 1'b1;
            end
         end else begin
            active_delay_in = cfg.standard_repeat;
            last_key_in     = KEY_NONE;
            if (elapsed > {{(TICK_W-REG_W){1'b0}}, cfg.idle_timeout} && screen_now) begin
               screen_in           = 1'b0;
               fire                = 1'b1;
               out_item.key_code   = KEY_NONE;
               out_item.event_kind = EVENT_TIMEOUT;
            end
         end
      end
      out_item.screen_on = screen_in;
      out_push = item_pop && fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_key_ff     <= KEY_NONE;
         last_event_ff   <= '0;
         active_delay_ff <= STANDARD_RESET;
         screen_ff       <= 1'b1;
      end else if (item_pop) begin
         last_key_ff     <= last_key_in;
         last_event_ff   <= last_event_in;
         active_delay_ff <= active_delay_in;
         screen_ff       <= screen_in;
      end
   end

endmodule

// ----- hw/rtl/resistor_ladder_keypad_controller.sv -----
// ----------------------------------------------------------------------------
// resistor_ladder_keypad_controller
// Keypad controller for a three-button resistor ladder: debounce,
// autorepeat and screen idle timeout.
// ----------------------------------------------------------------------------
// Each pushed item is one sample tick. The front decodes the reading and
// checks it against the previous tick; a queue of QUEUE_DEPTH entries then
// feeds the back, which tracks the held key, repeat timing and the screen
// state, and writes events into a result queue of the same depth. One item
// is taken every cycle while the input queue has room; its sample passes the
// input queue registers and its event the result queue registers before it
// shows on the result ports, and a full result queue holds it back. Write
// configuration only while no samples or events are in flight.
module resistor_ladder_keypad_controller #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [rlkc_pkg::ADC_W-1:0]         req_adc_sample,
   input  logic                               req_key_line_high,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [rlkc_pkg::CODE_W-1:0]        rsp_key_code,
   output logic                               rsp_event_kind,
   output logic                               rsp_screen_on,
   input  logic                               csr_we,
   input  logic [rlkc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rlkc_pkg::REG_W-1:0]         csr_wdata
);
   import rlkc_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   class_item_type front_item, back_item;
   logic           req_accept;
   logic           mid_empty, back_pop;
   logic           out_full, out_push;
   rsp_item_type   out_item, rsp_item;

   assign req_accept = req_push && !req_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STANDARD: cfg_in.standard_repeat = csr_wdata;
            CSR_REDUCED:  cfg_in.reduced_repeat  = csr_wdata;
            CSR_IDLE:     cfg_in.idle_timeout    = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.standard_repeat <= STANDARD_RESET;
         cfg_ff.reduced_repeat  <= REDUCED_RESET;
         cfg_ff.idle_timeout    <= IDLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rlkc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .adc_sample    (req_adc_sample),
      .key_line_high (req_key_line_high),
      .item          (front_item)
   );

   rlkc_queue #(
      .WIDTH ($bits(class_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_item),
      .full      (req_full),
      .pop       (back_pop),
      .pop_data  (back_item),
      .empty     (mid_empty)
   );

   rlkc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (back_item),
      .item_valid (!mid_empty),
      .item_pop   (back_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_item   (out_item)
   );

   rlkc_queue #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_item),
      .empty     (rsp_empty)
   );

   assign rsp_key_code   = rsp_item.key_code;
   assign rsp_event_kind = rsp_item.event_kind;
   assign rsp_screen_on  = rsp_item.screen_on;

   a_timeout_shape : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_event_kind == EVENT_TIMEOUT) |->
         (rsp_key_code == KEY_NONE && !rsp_screen_on))
      else $error("timeout event with key code or screen on");

   a_key_shape : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_event_kind == EVENT_KEY) |->
         (rsp_key_code != KEY_NONE && rsp_screen_on))
      else $error("key event without key or with screen off");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

endmodule

// ----- bench/keypad_event_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_event_checker
// Watches the sample and event channels of the keypad controller, predicts
// every key and idle-timeout event from the accepted samples and the register
// writes, and compares each popped event field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module keypad_event_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic                           req_full,
   input  logic [rlkc_pkg::ADC_W-1:0]     req_adc_sample,
   input  logic                           req_key_line_high,
   input  logic                           rsp_empty,
   input  logic                           rsp_pop,
   input  logic [rlkc_pkg::CODE_W-1:0]    rsp_key_code,
   input  logic                           rsp_event_kind,
   input  logic                           rsp_screen_on,
   input  logic                           csr_we,
   input  logic [rlkc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rlkc_pkg::REG_W-1:0]     csr_wdata,
   output int                             events_waiting,
   output int                             mismatch_count
);
   import rlkc_pkg::*;

   reg_type  standard_ticks;
   reg_type  reduced_ticks;
   reg_type  idle_ticks;

   code_type prior_code;
   code_type held_key;
   tick_type last_event_date;
   reg_type  repeat_delay;
   tick_type sample_date;
   logic     backlight;

   rsp_item_type expected_events[$];
   rsp_item_type predicted;
   rsp_item_type wanted;
   int           errors = 0;

   function automatic code_type ladder_code(input logic [ADC_W-1:0] s, input logic line);
      if (!line || s <= THR_MIN || s >= THR_ALL) return KEY_NONE;
      if (s < THR_UP)   return KEY_UP;
      if (s < THR_DOWN) return KEY_DOWN;
      if (s < THR_SEL)  return KEY_SELECT;
      if (s < THR_UD)   return KEY_UP | KEY_DOWN;
      if (s < THR_US)   return KEY_UP | KEY_SELECT;
      if (s < THR_DS)   return KEY_DOWN | KEY_SELECT;
      return KEY_UP | KEY_DOWN | KEY_SELECT;
   endfunction

   // advance the keypad state by one sample tick; returns 1 when an event is due
   function automatic bit step_sample(input logic [ADC_W-1:0] s, input logic line,
                                      output rsp_item_type ev);
      code_type code;
      tick_type date;
      tick_type elapsed;
      bit       agreed;
      bit       hit;
      code = ladder_code(s, line);
      date = sample_date;
      hit = 1'b0;
      ev = '0;
      agreed = (code == prior_code);
      sample_date = sample_date + 1;
      prior_code = code;
      if (line) backlight = 1'b1;
      if (agreed) begin
         elapsed = date - last_event_date;
         if (code != KEY_NONE) begin
            if (code != held_key || elapsed > tick_type'(repeat_delay)) begin
               repeat_delay = (code == held_key) ? reduced_ticks : standard_ticks;
               held_key = code;
               last_event_date = date;
               ev.key_code = code;
               ev.event_kind = EVENT_KEY;
               hit = 1'b1;
            end
         end else begin
            repeat_delay = standard_ticks;
            held_key = KEY_NONE;
            if (elapsed > tick_type'(idle_ticks) && backlight) begin
               backlight = 1'b0;
               ev.key_code = KEY_NONE;
               ev.event_kind = EVENT_TIMEOUT;
               hit = 1'b1;
            end
         end
      end
      ev.screen_on = backlight;
      return hit;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         standard_ticks = STANDARD_RESET;
         reduced_ticks = REDUCED_RESET;
         idle_ticks = IDLE_RESET;
         prior_code = KEY_NONE;
         held_key = KEY_NONE;
         last_event_date = '0;
         repeat_delay = STANDARD_RESET;
         sample_date = '0;
         backlight = 1'b1;
         expected_events.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_events.size() == 0) begin
               errors++;
               $display("%0t: event with none expected: key_code %0d event_kind %0d screen_on %0d",
                        $time, rsp_key_code, rsp_event_kind, rsp_screen_on);
            end else begin
               wanted = expected_events.pop_front();
               if (rsp_key_code !== wanted.key_code) begin
                  errors++;
                  $display("%0t: key_code expected %0d actual %0d",
                           $time, wanted.key_code, rsp_key_code);
               end
               if (rsp_event_kind !== wanted.event_kind) begin
                  errors++;
                  $display("%0t: event_kind expected %0d actual %0d",
                           $time, wanted.event_kind, rsp_event_kind);
               end
               if (rsp_screen_on !== wanted.screen_on) begin
                  errors++;
                  $display("%0t: screen_on expected %0d actual %0d",
                           $time, wanted.screen_on, rsp_screen_on);
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_STANDARD: standard_ticks = csr_wdata;
               CSR_REDUCED:  reduced_ticks = csr_wdata;
               CSR_IDLE:     idle_ticks = csr_wdata;
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            if (step_sample(req_adc_sample, req_key_line_high, predicted))
               expected_events.push_back(predicted);
         end
      end
      events_waiting <= expected_events.size();
      mismatch_count <= errors;
   end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives ladder samples and register writes into the keypad controller with
// random gaps and result stalls, and gives the verdict from the checker's
// mismatch count.
// ----------------------------------------------------------------------------
module testbench;
   import rlkc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 16;
   localparam int STALL_LIMIT  = 4000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [ADC_W-1:0]     req_adc_sample = '0;
   logic                 req_key_line_high = 1'b0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [CODE_W-1:0]    rsp_key_code;
   logic                 rsp_event_kind;
   logic                 rsp_screen_on;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0]     csr_wdata = '0;

   int events_waiting;
   int mismatch_count;
   int idle_cycles = 0;
   bit steady = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   resistor_ladder_keypad_controller DUT (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_adc_sample    (req_adc_sample),
      .req_key_line_high (req_key_line_high),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_key_code      (rsp_key_code),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_screen_on     (rsp_screen_on),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   keypad_event_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_adc_sample    (req_adc_sample),
      .req_key_line_high (req_key_line_high),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_key_code      (rsp_key_code),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_screen_on     (rsp_screen_on),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .events_waiting    (events_waiting),
      .mismatch_count    (mismatch_count)
   );

   // watchdog: count cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: random stalls, mostly short, a few long, with free-running stretches
   initial begin : event_drain
      int stall;
      int free_run;
      int r;
      stall = 0;
      free_run = 0;
      forever begin
         @(posedge clock);
         if (free_run > 0) begin
            free_run--;
            rsp_pop <= 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_pop <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 4)
               free_run = $urandom_range(30, 200);
            else if (r < 30)
               stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                  : $urandom_range(1, 4);
            rsp_pop <= (stall == 0);
            if (stall > 0) stall--;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // hold push high across back-to-back transfers; drop it only for a gap
   task automatic push_sample(input logic [ADC_W-1:0] adc, input logic line);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_adc_sample <= adc;
      req_key_line_high <= line;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic write_config(input reg_type standard, input reg_type reduced,
                               input reg_type idle);
      req_push <= 1'b0;
      @(posedge clock);
      while (events_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_STANDARD;
      csr_wdata <= standard;
      @(posedge clock);
      csr_index <= CSR_REDUCED;
      csr_wdata <= reduced;
      @(posedge clock);
      csr_index <= CSR_IDLE;
      csr_wdata <= idle;
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= reg_type'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // held keys with occasional glitches, releases, and bursts of noise
   task automatic random_keypad(input int n_items, input int hold_max, input int release_max);
      int       sent;
      int       len;
      int       r;
      int       lo;
      int       hi;
      code_type key;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 99);
         steady = ($urandom_range(0, 3) == 0);
         if (r < 60) begin
            key = code_type'($urandom_range(1, 7));
            case (key)
               KEY_UP:                begin lo = THR_MIN + 1; hi = THR_UP - 1;   end
               KEY_DOWN:              begin lo = THR_UP;      hi = THR_DOWN - 1; end
               KEY_SELECT:            begin lo = THR_DOWN;    hi = THR_SEL - 1;  end
               KEY_UP | KEY_DOWN:     begin lo = THR_SEL;     hi = THR_UD - 1;   end
               KEY_UP | KEY_SELECT:   begin lo = THR_UD;      hi = THR_US - 1;   end
               KEY_DOWN | KEY_SELECT: begin lo = THR_US;      hi = THR_DS - 1;   end
               default:               begin lo = THR_DS;      hi = THR_ALL - 1;  end
            endcase
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, hold_max)
                                              : $urandom_range(1, 12);
            repeat (len) begin
               if ($urandom_range(0, 29) == 0)
                  push_sample(ADC_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
               else
                  push_sample(ADC_W'($urandom_range(hi, lo)), 1'b1);
               sent++;
            end
         end else if (r < 85) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, release_max)
                                              : $urandom_range(1, 6);
            repeat (len) begin
               case ($urandom_range(0, 2))
                  0:       push_sample(ADC_W'($urandom_range(0, 1023)), 1'b0);
                  1:       push_sample(ADC_W'($urandom_range(0, THR_MIN)), 1'b1);
                  default: push_sample(ADC_W'($urandom_range(THR_ALL, 1023)), 1'b1);
               endcase
               sent++;
            end
         end else begin
            len = $urandom_range(1, 4);
            repeat (len) begin
               push_sample(ADC_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // band edges of the ladder, unstable samples and wake without a key
      push_sample(10'd0, 1'b0);
      push_sample(10'd0, 1'b0);
      push_sample(10'd501, 1'b1);
      push_sample(10'd579, 1'b1);
      push_sample(10'd580, 1'b1);
      push_sample(10'd649, 1'b1);
      push_sample(10'd650, 1'b1);
      push_sample(10'd719, 1'b1);
      push_sample(10'd720, 1'b1);
      push_sample(10'd764, 1'b1);
      push_sample(10'd765, 1'b1);
      push_sample(10'd793, 1'b1);
      push_sample(10'd794, 1'b1);
      push_sample(10'd823, 1'b1);
      push_sample(10'd824, 1'b1);
      push_sample(10'd899, 1'b1);
      push_sample(10'd900, 1'b1);
      push_sample(10'd500, 1'b1);
      push_sample(10'd1023, 1'b1);
      push_sample(10'd1023, 1'b0);
      push_sample(10'd579, 1'b1);
      push_sample(10'd501, 1'b1);
      push_sample(10'd540, 1'b1);
      push_sample(10'd0, 1'b1);
      random_keypad(250, 40, 60);

      write_config(16'd0, 16'd0, 16'd0);
      random_keypad(300, 30, 10);

      write_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_keypad(250, 60, 40);

      write_config(16'd7, 16'd2, 16'd30);
      random_keypad(450, 60, 60);

      write_config(reg_type'($urandom_range(0, 20)), reg_type'($urandom_range(0, 8)),
                   reg_type'($urandom_range(0, 100)));
      random_keypad(450, 150, 150);

      req_push <= 1'b0;
      @(posedge clock);
      while (events_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
